>>> rtl/obstacle_speed_governor_unit_defines.svh
// ----------------------------------------------------------------------------
// Obstacle speed governor assertion macros
// Shared property wrappers for the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_SPEED_GOVERNOR_UNIT_DEFINES_SVH
`define OBSTACLE_SPEED_GOVERNOR_UNIT_DEFINES_SVH

// Property checked only outside of reset.
`define OSG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define OSG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/osg_pkg.sv
// ----------------------------------------------------------------------------
// Obstacle speed governor package
// Item kinds, register indexes, limiter constants, shared types and helpers.
// ----------------------------------------------------------------------------
package osg_pkg;

  // Item kinds, encoded as the func field of an input request.
  typedef enum logic [1:0] {
    KIND_LASER = 2'd0,
    KIND_SONAR = 2'd1,
    KIND_JOY   = 2'd2,
    KIND_CYCLE = 2'd3
  } osg_kind_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMITER_ENABLE = 3'd0,
    REG_STOP_DISTANCE  = 3'd1,
    REG_NEAR_DISTANCE  = 3'd2,
    REG_FAR_DISTANCE   = 3'd3,
    REG_SCAN_POINTS    = 3'd4
  } osg_reg_t;

  // Limit source codes.
  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_SONAR = 2'd1,
    SRC_LASER = 2'd2
  } osg_src_t;

  // Configuration reset values.
  localparam logic        RST_LIMITER_ENABLE = 1'b0;
  localparam logic [15:0] RST_STOP_DISTANCE  = 16'd600;
  localparam logic [15:0] RST_NEAR_DISTANCE  = 16'd1200;
  localparam logic [15:0] RST_FAR_DISTANCE   = 16'd2000;
  localparam logic [10:0] RST_SCAN_POINTS    = 11'd720;

  // Command clamps and deadbands.
  localparam logic signed [15:0] ADV_CLAMP_HI  = 16'sd1000;
  localparam logic signed [15:0] ADV_CLAMP_LO  = -16'sd1000;
  localparam logic signed [15:0] TURN_CLAMP_HI = 16'sd100;
  localparam logic signed [15:0] TURN_CLAMP_LO = -16'sd100;
  localparam logic signed [10:0] ADV_DEADBAND  = 11'sd40;
  localparam logic signed [7:0]  TURN_DEADBAND = 8'sd2;

  // Laser repair floor and the empty running minimum.
  localparam logic [15:0] FILL_FLOOR = 16'd200;
  localparam logic [15:0] MIN_EMPTY  = 16'hFFFF;

  // Fixed-point constants: degrees to 1/4096 rad in Q16, 1/10 and 1/3 reciprocals.
  localparam logic [22:0] DEG_TO_Q16  = 23'd4685272;
  localparam logic [15:0] ROUND_HALF  = 16'd32768;
  localparam logic [12:0] RECIP_TEN   = 13'd6554;
  localparam int          TEN_SHIFT   = 16;
  localparam logic [15:0] RECIP_THREE = 16'd43691;
  localparam int          THREE_SHIFT = 17;
  localparam int          SCAN_MIN_PTS = 3;

  // Front-to-back queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // One classified item as it travels through the queue.
  typedef struct packed {
    osg_kind_t          kind;
    logic               side;
    logic               first;
    logic [15:0]        distance;
    logic [3:0]         sonar_idx;
    logic signed [10:0] adv;
    logic signed [7:0]  turn;
    logic               link_ok;
  } osg_item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic        limiter_enable;
    logic [15:0] stop_distance;
    logic [15:0] near_distance;
    logic [15:0] far_distance;
    logic [10:0] scan_points;
  } osg_cfg_t;

  // Magnitude of a signed advance value.
  function automatic logic [10:0] osg_abs11(input logic signed [10:0] x);
    return x[10] ? 11'(-x) : 11'(x);
  endfunction

  // Magnitude of a signed turn value.
  function automatic logic [7:0] osg_abs8(input logic signed [7:0] x);
    return x[7] ? 8'(-x) : 8'(x);
  endfunction

  // Smallest of four distances.
  function automatic logic [15:0] osg_min4(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c, input logic [15:0] d);
    logic [15:0] ab;
    logic [15:0] cd;
    ab = (a < b) ? a : b;
    cd = (c < d) ? c : d;
    return (ab < cd) ? ab : cd;
  endfunction

  // Distance band selection: stop, tenth, four tenths or unchanged.
  function automatic logic signed [10:0] osg_band(input logic [15:0] d, input osg_cfg_t c,
                                                  input logic signed [10:0] adv,
                                                  input logic signed [10:0] q10,
                                                  input logic signed [10:0] q4);
    logic signed [10:0] r;
    if (d < c.stop_distance) begin
      r = '0;
    end else if (d < c.near_distance) begin
      r = q10;
    end else if (d < c.far_distance) begin
      r = q4;
    end else begin
      r = adv;
    end
    return r;
  endfunction

endpackage

>>> rtl/osg_if.sv
// ----------------------------------------------------------------------------
// Obstacle speed governor channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------

// Input item channel.
interface osg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic               laser_side;
  logic               first_sample;
  logic [15:0]        distance;
  logic [3:0]         sonar_index;
  logic signed [15:0] advance_cmd;
  logic signed [15:0] turn_cmd;
  logic               link_ok;

  modport source (output valid, func, laser_side, first_sample, distance, sonar_index,
                  advance_cmd, turn_cmd, link_ok, input ready);
  modport sink (input valid, func, laser_side, first_sample, distance, sonar_index,
                advance_cmd, turn_cmd, link_ok, output ready);
endinterface

// Result item channel.
interface osg_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] advance_speed;
  logic signed [13:0] turn_rate;
  logic [1:0]         limit_source;

  modport source (output valid, advance_speed, turn_rate, limit_source, input ready);
  modport sink (input valid, advance_speed, turn_rate, limit_source, output ready);
endinterface

// Configuration write channel.
interface osg_cfg_if import osg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/osg_cfg_regs.sv
// ----------------------------------------------------------------------------
// Obstacle speed governor configuration registers
// Takes register writes and holds the limiter thresholds and scan length.
// ----------------------------------------------------------------------------
module osg_cfg_regs import osg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  osg_cfg_if.sink  cfg_chan,
  output osg_cfg_t cfg
);

  osg_cfg_t cfg_r;
  osg_cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_chan.ready = 1'b1;
  assign cfg             = cfg_r;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_LIMITER_ENABLE: cfg_nxt.limiter_enable = cfg_chan.data[0];
        REG_STOP_DISTANCE:  cfg_nxt.stop_distance  = cfg_chan.data;
        REG_NEAR_DISTANCE:  cfg_nxt.near_distance  = cfg_chan.data;
        REG_FAR_DISTANCE:   cfg_nxt.far_distance   = cfg_chan.data;
        REG_SCAN_POINTS:    cfg_nxt.scan_points    = cfg_chan.data[10:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register file with reset defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limiter_enable <= RST_LIMITER_ENABLE;
      cfg_r.stop_distance  <= RST_STOP_DISTANCE;
      cfg_r.near_distance  <= RST_NEAR_DISTANCE;
      cfg_r.far_distance   <= RST_FAR_DISTANCE;
      cfg_r.scan_points    <= RST_SCAN_POINTS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/osg_front.sv
// ----------------------------------------------------------------------------
// Obstacle speed governor front end
// Accepts input requests, classifies them and clamps joystick commands.
// ----------------------------------------------------------------------------
module osg_front import osg_pkg::*; (
  osg_in_if.sink    in_chan,
  input  logic      q_full,
  output logic      push,
  output osg_item_t item
);

  // Accept whenever the queue has room.
  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  // Classify the request and clamp the joystick axes to their ranges.
  always_comb begin
    item.kind      = osg_kind_t'(in_chan.func);
    item.side      = in_chan.laser_side;
    item.first     = in_chan.first_sample;
    item.distance  = in_chan.distance;
    item.sonar_idx = in_chan.sonar_index;
    item.link_ok   = in_chan.link_ok;

    if (in_chan.advance_cmd > ADV_CLAMP_HI) begin
      item.adv = ADV_CLAMP_HI[10:0];
    end else if (in_chan.advance_cmd < ADV_CLAMP_LO) begin
      item.adv = ADV_CLAMP_LO[10:0];
    end else begin
      item.adv = in_chan.advance_cmd[10:0];
    end

    if (in_chan.turn_cmd > TURN_CLAMP_HI) begin
      item.turn = TURN_CLAMP_HI[7:0];
    end else if (in_chan.turn_cmd < TURN_CLAMP_LO) begin
      item.turn = TURN_CLAMP_LO[7:0];
    end else begin
      item.turn = in_chan.turn_cmd[7:0];
    end
  end

endmodule

>>> rtl/osg_queue.sv
// ----------------------------------------------------------------------------
// Obstacle speed governor item queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module osg_queue import osg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  osg_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output osg_item_t head
);

  osg_item_t       q_mem_r [Q_DEPTH];
  logic [Q_AW:0]   wr_ptr_r;
  logic [Q_AW:0]   rd_ptr_r;

  // Pointers carry one wrap bit to tell full from empty.
  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[Q_AW] != rd_ptr_r[Q_AW]) &&
                 (wr_ptr_r[Q_AW-1:0] == rd_ptr_r[Q_AW-1:0]);
  assign head  = q_mem_r[rd_ptr_r[Q_AW-1:0]];

  // Pointer update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r[Q_AW-1:0]] <= push_item;
    end
  end

endmodule

>>> rtl/osg_back.sv
// ----------------------------------------------------------------------------
// Obstacle speed governor back end
// Applies laser, sonar and joystick updates and runs the limiter pipeline.
// ----------------------------------------------------------------------------
module osg_back import osg_pkg::*; #(
  parameter int MAX_SCAN    = 1024,
  parameter int SONAR_COUNT = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  osg_cfg_t  cfg,
  input  logic      q_empty,
  input  osg_item_t head,
  output logic      pop,
  osg_out_if.source out_chan
);

  localparam int IDX_W = $clog2(MAX_SCAN + 1);
  localparam int CW    = (IDX_W > 11) ? IDX_W : 11;
  localparam int PW    = IDX_W + 16;
  localparam int SW    = $clog2(SONAR_COUNT);

  // Stored scan, sonar and command state.
  logic [IDX_W-1:0]   scan_index_r  [2];
  logic [15:0]        fill_value_r  [2];
  logic [15:0]        running_min_r [2];
  logic [15:0]        scan_min_r    [2];
  logic [15:0]        sonar_r       [SONAR_COUNT];
  logic signed [10:0] held_advance_r;
  logic signed [7:0]  held_turn_r;

  // Pipeline registers.
  logic               b_valid_r;
  logic signed [10:0] b_adv_r;
  logic signed [7:0]  b_rot_r;
  logic [15:0]        b_las_d_r;
  logic [15:0]        b_son_d_r;
  logic               c_valid_r;
  logic signed [10:0] c_adv_r;
  logic signed [10:0] c_q10_r;
  logic signed [10:0] c_q4_r;
  logic signed [13:0] c_turn_r;
  logic [15:0]        c_las_d_r;
  logic [15:0]        c_son_d_r;
  logic               out_valid_r;
  logic signed [10:0] out_adv_r;
  logic signed [13:0] out_turn_r;
  osg_src_t           out_src_r;

  // The whole back end advances while the output register is free or being taken.
  logic en;
  logic take;
  assign en   = !out_valid_r || out_chan.ready;
  assign pop  = en && !q_empty;
  assign take = pop;

  // Scan geometry from the configured length, saturated to the legal range.
  logic [CW-1:0]    sp_ext;
  logic [IDX_W-1:0] n_c;
  logic [PW-1:0]    lim_prod;
  logic [IDX_W-1:0] lim_c;
  logic [IDX_W-1:0] hi_c;
  logic [IDX_W-1:0] last_c;

  always_comb begin
    sp_ext = CW'(cfg.scan_points);
    if (sp_ext < CW'(SCAN_MIN_PTS)) begin
      n_c = IDX_W'(SCAN_MIN_PTS);
    end else if (sp_ext > CW'(MAX_SCAN)) begin
      n_c = IDX_W'(MAX_SCAN);
    end else begin
      n_c = sp_ext[IDX_W-1:0];
    end
    lim_prod = PW'(n_c) * PW'(RECIP_THREE);
    lim_c    = IDX_W'(lim_prod >> THREE_SHIFT);
    hi_c     = n_c - lim_c;
    last_c   = n_c - 1'b1;
  end

  // Laser sample repair and middle-third minimum for the addressed scan.
  logic             side;
  logic             restart;
  logic [IDX_W-1:0] idx_e;
  logic [15:0]      rmin;
  logic [15:0]      fill_v;
  logic [15:0]      rmin_nxt;

  always_comb begin
    side    = head.side;
    restart = head.first || (scan_index_r[side] >= n_c);
    idx_e   = restart ? '0 : scan_index_r[side];
    rmin    = restart ? MIN_EMPTY : running_min_r[side];
    if (head.distance < FILL_FLOOR) begin
      fill_v = (idx_e == '0) ? FILL_FLOOR : fill_value_r[side];
    end else begin
      fill_v = head.distance;
    end
    if ((idx_e >= lim_c) && (idx_e < hi_c) && (fill_v < rmin)) begin
      rmin_nxt = fill_v;
    end else begin
      rmin_nxt = rmin;
    end
  end

  // Control cycle front half: link check, deadbands and distance selection.
  logic signed [10:0] adv_h;
  logic signed [7:0]  rot_h;
  logic signed [10:0] adv_db;
  logic signed [7:0]  rot_db;
  logic [15:0]        son_front;
  logic [15:0]        son_rear;
  logic [15:0]        las_d;
  logic [15:0]        son_d;

  always_comb begin
    adv_h = head.link_ok ? held_advance_r : '0;
    rot_h = head.link_ok ? held_turn_r : '0;
    if ((adv_h > -ADV_DEADBAND) && (adv_h < ADV_DEADBAND)) begin
      adv_db = '0;
    end else begin
      adv_db = adv_h;
    end
    if ((rot_h > -TURN_DEADBAND) && (rot_h < TURN_DEADBAND)) begin
      rot_db = '0;
    end else begin
      rot_db = rot_h;
    end
    son_front = osg_min4(sonar_r[2], sonar_r[3], sonar_r[4], sonar_r[5]);
    son_rear  = osg_min4(sonar_r[10], sonar_r[11], sonar_r[12], sonar_r[13]);
    las_d     = adv_db[10] ? scan_min_r[1] : scan_min_r[0];
    son_d     = (!adv_db[10] && (adv_db != '0)) ? son_front : son_rear;
  end

  // State updates for laser, sonar, joystick and link loss.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        scan_index_r[s]  <= '0;
        fill_value_r[s]  <= '0;
        running_min_r[s] <= MIN_EMPTY;
        scan_min_r[s]    <= '0;
      end
      for (int k = 0; k < SONAR_COUNT; k++) begin
        sonar_r[k] <= '0;
      end
      held_advance_r <= '0;
      held_turn_r    <= '0;
    end else if (take) begin
      case (head.kind)
        KIND_LASER: begin
          fill_value_r[side]  <= fill_v;
          running_min_r[side] <= rmin_nxt;
          scan_index_r[side]  <= idx_e + 1'b1;
          if (idx_e == last_c) begin
            scan_min_r[side] <= rmin_nxt;
          end
        end
        KIND_SONAR: begin
          if (32'(head.sonar_idx) < SONAR_COUNT) begin
            sonar_r[SW'(head.sonar_idx)] <= head.distance;
          end
        end
        KIND_JOY: begin
          held_advance_r <= head.adv;
          held_turn_r    <= head.turn;
        end
        KIND_CYCLE: begin
          if (!head.link_ok) begin
            held_advance_r <= '0;
            held_turn_r    <= '0;
          end
        end
        default: begin
          held_advance_r <= held_advance_r;
        end
      endcase
    end
  end

  // Stage B: scaled advance magnitudes and turn conversion.
  logic [10:0]        adv_mag;
  logic [23:0]        p10;
  logic [25:0]        p4;
  logic [10:0]        q10_u;
  logic [10:0]        q4_u;
  logic signed [10:0] q10_s;
  logic signed [10:0] q4_s;
  logic [7:0]         rot_mag;
  logic [29:0]        tp;
  logic [13:0]        tmag;
  logic signed [13:0] turn_s;

  always_comb begin
    adv_mag = osg_abs11(b_adv_r);
    p10     = 24'(adv_mag) * 24'(RECIP_TEN);
    p4      = 26'({adv_mag, 2'b00}) * 26'(RECIP_TEN);
    q10_u   = 11'(p10 >> TEN_SHIFT);
    q4_u    = 11'(p4 >> TEN_SHIFT);
    q10_s   = b_adv_r[10] ? 11'(-$signed(q10_u)) : $signed(q10_u);
    q4_s    = b_adv_r[10] ? 11'(-$signed(q4_u)) : $signed(q4_u);
    rot_mag = osg_abs8(b_rot_r);
    tp      = 30'(rot_mag) * 30'(DEG_TO_Q16) + 30'(ROUND_HALF);
    tmag    = 14'(tp >> TEN_SHIFT);
    turn_s  = b_rot_r[7] ? 14'(-$signed(tmag)) : $signed(tmag);
  end

  // Stage C: bands, rear stop on turn and choice of the tighter limit.
  logic signed [10:0] las_v;
  logic signed [10:0] son_v;
  logic               son_stop;
  logic signed [10:0] adv_o;
  logic signed [13:0] turn_o;
  osg_src_t           src_o;

  always_comb begin
    las_v    = osg_band(c_las_d_r, cfg, c_adv_r, c_q10_r, c_q4_r);
    son_v    = osg_band(c_son_d_r, cfg, c_adv_r, c_q10_r, c_q4_r);
    son_stop = c_son_d_r < cfg.stop_distance;
    adv_o    = c_adv_r;
    turn_o   = c_turn_r;
    src_o    = SRC_NONE;
    if (cfg.limiter_enable) begin
      if (son_stop && (c_adv_r[10] || (c_adv_r == '0))) begin
        turn_o = '0;
      end
      if ((las_v == son_v) && (las_v == c_adv_r)) begin
        src_o = SRC_NONE;
      end else if (osg_abs11(son_v) <= osg_abs11(las_v)) begin
        adv_o = son_v;
        src_o = SRC_SONAR;
      end else begin
        adv_o = las_v;
        src_o = SRC_LASER;
      end
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r   <= take && (head.kind == KIND_CYCLE);
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (en) begin
      b_adv_r   <= adv_db;
      b_rot_r   <= rot_db;
      b_las_d_r <= las_d;
      b_son_d_r <= son_d;
      c_adv_r   <= b_adv_r;
      c_q10_r   <= q10_s;
      c_q4_r    <= q4_s;
      c_turn_r  <= turn_s;
      c_las_d_r <= b_las_d_r;
      c_son_d_r <= b_son_d_r;
      if (c_valid_r) begin
        out_adv_r  <= adv_o;
        out_turn_r <= turn_o;
        out_src_r  <= src_o;
      end
    end
  end

  // Result channel.
  assign out_chan.valid         = out_valid_r;
  assign out_chan.advance_speed = out_adv_r;
  assign out_chan.turn_rate     = out_turn_r;
  assign out_chan.limit_source  = out_src_r;

endmodule

>>> rtl/obstacle_speed_governor_unit.sv
// ----------------------------------------------------------------------------
// Obstacle speed governor: takes one item per cycle while the queue has room;
// limiter results pass stage B, stage C and the output, one per cycle if taken.
// Synchronous active-low reset sets defaults, clears all but data registers.
// ----------------------------------------------------------------------------
module obstacle_speed_governor_unit import osg_pkg::*; #(
  parameter int MAX_SCAN    = 1024,
  parameter int SONAR_COUNT = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  osg_in_if.sink    in_chan,
  osg_out_if.source out_chan,
  osg_cfg_if.sink   cfg_chan
);

  osg_cfg_t  cfg;
  osg_item_t push_item;
  osg_item_t head;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;

  // Configuration registers.
  osg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // Accept and classify requests.
  osg_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push),
    .item    (push_item)
  );

  // Decoupling queue.
  osg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // State updates and limiter pipeline.
  osg_back #(
    .MAX_SCAN    (MAX_SCAN),
    .SONAR_COUNT (SONAR_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

>>> rtl/osg_chk.sv
// ----------------------------------------------------------------------------
// Obstacle speed governor checker
// Port-level properties of the governor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "obstacle_speed_governor_unit_defines.svh"

module osg_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [10:0] out_advance_speed,
  input logic signed [13:0] out_turn_rate,
  input logic [1:0]         out_limit_source
);

  // Reset leaves no result pending and the queue open.
  `OSG_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && in_ready, "reset not idle")

  // A stalled result holds.
  `OSG_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_advance_speed) && $stable(out_turn_rate) && $stable(out_limit_source), "stalled result changed")

  // Advance stays within the clamp.
  `OSG_ASSERT(a_adv_range, clk, rst_n, out_valid |-> (out_advance_speed <= 11'sd1000) && (out_advance_speed >= -11'sd1000), "advance out of range")

  // Turn stays within the converted clamp.
  `OSG_ASSERT(a_turn_range, clk, rst_n, out_valid |-> (out_turn_rate <= 14'sd7149) && (out_turn_rate >= -14'sd7149), "turn out of range")

  // Limit source is a defined code.
  `OSG_ASSERT(a_src_code, clk, rst_n, out_valid |-> out_limit_source != 2'd3, "bad limit source")

endmodule

bind obstacle_speed_governor_unit osg_chk u_osg_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_advance_speed (out_chan.advance_speed),
  .out_turn_rate     (out_chan.turn_rate),
  .out_limit_source  (out_chan.limit_source)
);

>>> tb/obstacle_speed_governor_unit_test.sv
// ----------------------------------------------------------------------------
// Obstacle speed governor unit test
// Streams laser samples, sonar readings, joystick commands and control cycles
// into the governor. A request-level predictor tracks scan repair, middle-third
// minima, sonar groups and the distance bands, and every speed result is
// compared field by field. Register settings step through their extremes, and
// both channels idle and stall at random, including one long output stall.
// ----------------------------------------------------------------------------
module obstacle_speed_governor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import osg_pkg::*;

  localparam int          RESET_CYCLES     = 11;
  localparam int unsigned IDLE_PCT         = 21;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          STALL_CYCLES     = 300;
  localparam int          RANDOM_PER_PHASE = 60;
  localparam int          SCAN_CAP         = 1024;
  localparam int          SCAN_FLOOR       = 3;
  localparam int          LASER_FLOOR      = 200;
  localparam int          ADV_LIMIT        = 1000;
  localparam int          TURN_LIMIT       = 100;
  localparam int          ADV_DEAD         = 40;
  localparam int          TURN_DEAD        = 2;
  localparam longint      DEG_Q16          = 4685272;
  localparam longint      Q16_HALF         = 32768;

  // One input request as driven onto the input channel.
  typedef struct packed {
    osg_kind_t          func;
    logic               laser_side;
    logic               first_sample;
    logic [15:0]        distance;
    logic [3:0]         sonar_index;
    logic signed [15:0] advance_cmd;
    logic signed [15:0] turn_cmd;
    logic               link_ok;
  } drive_req_t;

  // One expected speed result.
  typedef struct packed {
    logic signed [10:0] advance_speed;
    logic signed [13:0] turn_rate;
    osg_src_t           limit_source;
  } speed_result_t;

  logic clk;
  logic rst_n;

  osg_in_if  in_chan ();
  osg_out_if out_chan ();
  osg_cfg_if cfg_chan ();

  obstacle_speed_governor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predictor state: registers, laser scans, sonar readings, held command.
  osg_cfg_t           cfg_model;
  int                 scan_pos[2];
  logic [15:0]        fill_val[2];
  logic [15:0]        run_min[2];
  logic [15:0]        last_min[2];
  logic [15:0]        sonar_mm[16];
  logic signed [10:0] joy_adv;
  logic signed [7:0]  joy_turn;

  speed_result_t expected_speeds[$];

  int          laser_cursor[2];
  bit          calm = 1'b0;
  int unsigned stall_request = 0;
  int unsigned stall_taken = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned speeds_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned kind_seen[4];

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("obstacle_speed_governor_unit_test: FAIL");
    $finish;
  end

  // Clear the predictor to its reset state.
  function automatic void reset_model();
    cfg_model.limiter_enable = RST_LIMITER_ENABLE;
    cfg_model.stop_distance  = RST_STOP_DISTANCE;
    cfg_model.near_distance  = RST_NEAR_DISTANCE;
    cfg_model.far_distance   = RST_FAR_DISTANCE;
    cfg_model.scan_points    = RST_SCAN_POINTS;
    for (int s = 0; s < 2; s++) begin
      scan_pos[s]     = 0;
      fill_val[s]     = '0;
      run_min[s]      = 16'hFFFF;
      last_min[s]     = '0;
      laser_cursor[s] = 0;
    end
    for (int i = 0; i < 16; i++) sonar_mm[i] = '0;
    joy_adv  = '0;
    joy_turn = '0;
  endfunction

  // Scan length as the block uses it, saturated to the legal range.
  function automatic int scan_len();
    int n;
    n = cfg_model.scan_points;
    if (n < SCAN_FLOOR) n = SCAN_FLOOR;
    if (n > SCAN_CAP) n = SCAN_CAP;
    return n;
  endfunction

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Distance band: stop, a tenth, four tenths or unchanged.
  function automatic int limit_band(input logic [15:0] d, input int adv, output bit stopped);
    stopped = 1'b0;
    if (d < cfg_model.stop_distance) begin
      stopped = 1'b1;
      return 0;
    end
    if (d < cfg_model.near_distance) return adv / 10;
    if (d < cfg_model.far_distance) return (adv * 4) / 10;
    return adv;
  endfunction

  // Nearest reading among four neighboring sonar sensors.
  function automatic logic [15:0] sonar_group_min(input int from);
    logic [15:0] m;
    m = 16'hFFFF;
    for (int i = from; i < from + 4; i++) begin
      if (sonar_mm[i] < m) m = sonar_mm[i];
    end
    return m;
  endfunction

  // Repair one laser sample and fold it into the middle-third minimum.
  function automatic void laser_update(input logic side, input logic first,
                                       input logic [15:0] d);
    int n;
    int third;
    int pos;
    logic [15:0] v;
    n = scan_len();
    third = n / 3;
    pos = scan_pos[side];
    if (first || pos >= n) begin
      pos = 0;
      run_min[side] = 16'hFFFF;
    end
    v = d;
    if (v < LASER_FLOOR) v = (pos == 0) ? 16'(LASER_FLOOR) : fill_val[side];
    fill_val[side] = v;
    if (pos >= third && pos < n - third && v < run_min[side]) run_min[side] = v;
    if (pos == n - 1) last_min[side] = run_min[side];
    scan_pos[side] = pos + 1;
  endfunction

  // Advance the predictor by one accepted request; control cycles queue a result.
  function automatic void predict_governor(input drive_req_t r);
    int adv;
    int rot;
    int turn;
    int las;
    int son;
    int mag;
    bit stop_l;
    bit stop_s;
    osg_src_t src;
    speed_result_t res;
    kind_seen[r.func]++;
    case (r.func)
      KIND_LASER: laser_update(r.laser_side, r.first_sample, r.distance);
      KIND_SONAR: sonar_mm[r.sonar_index] = r.distance;
      KIND_JOY: begin
        joy_adv  = 11'(clamp_int(int'(r.advance_cmd), -ADV_LIMIT, ADV_LIMIT));
        joy_turn = 8'(clamp_int(int'(r.turn_cmd), -TURN_LIMIT, TURN_LIMIT));
      end
      default: begin
        // A lost link drops the stored command before it is used.
        if (!r.link_ok) begin
          joy_adv  = '0;
          joy_turn = '0;
        end
        adv = joy_adv;
        rot = joy_turn;
        if (adv > -ADV_DEAD && adv < ADV_DEAD) adv = 0;
        if (rot > -TURN_DEAD && rot < TURN_DEAD) rot = 0;
        mag = (rot < 0) ? -rot : rot;
        turn = int'((longint'(mag) * DEG_Q16 + Q16_HALF) >>> 16);
        if (rot < 0) turn = -turn;
        src = SRC_NONE;
        if (cfg_model.limiter_enable) begin
          las = limit_band(last_min[(adv >= 0) ? 0 : 1], adv, stop_l);
          if (adv > 0) begin
            son = limit_band(sonar_group_min(2), adv, stop_s);
          end else begin
            son = limit_band(sonar_group_min(10), adv, stop_s);
            // A rear sonar stop also freezes rotation.
            if (stop_s) turn = 0;
          end
          if (las == son && las == adv) begin
            src = SRC_NONE;
          end else if (((son < 0) ? -son : son) <= ((las < 0) ? -las : las)) begin
            adv = son;
            src = SRC_SONAR;
          end else begin
            adv = las;
            src = SRC_LASER;
          end
        end
        res.advance_speed = 11'(adv);
        res.turn_rate     = 14'(turn);
        res.limit_source  = src;
        expected_speeds = {expected_speeds, res};
      end
    endcase
  endfunction

  // Request builders; fields the block ignores carry random values.
  function automatic drive_req_t base_req(input osg_kind_t kind);
    drive_req_t r;
    r.func         = kind;
    r.laser_side   = 1'($urandom);
    r.first_sample = 1'($urandom);
    r.distance     = 16'($urandom);
    r.sonar_index  = 4'($urandom);
    r.advance_cmd  = 16'($urandom);
    r.turn_cmd     = 16'($urandom);
    r.link_ok      = 1'($urandom);
    return r;
  endfunction

  function automatic drive_req_t laser_req(input logic side, input logic first,
                                           input logic [15:0] d);
    drive_req_t r;
    r = base_req(KIND_LASER);
    r.laser_side   = side;
    r.first_sample = first;
    r.distance     = d;
    return r;
  endfunction

  function automatic drive_req_t sonar_req(input logic [3:0] idx, input logic [15:0] d);
    drive_req_t r;
    r = base_req(KIND_SONAR);
    r.sonar_index = idx;
    r.distance    = d;
    return r;
  endfunction

  function automatic drive_req_t joy_req(input logic signed [15:0] adv,
                                         input logic signed [15:0] turn);
    drive_req_t r;
    r = base_req(KIND_JOY);
    r.advance_cmd = adv;
    r.turn_cmd    = turn;
    return r;
  endfunction

  function automatic drive_req_t cycle_req(input logic link);
    drive_req_t r;
    r = base_req(KIND_CYCLE);
    r.link_ok = link;
    return r;
  endfunction

  // Distances clustered on the floor and on the band edges.
  function automatic logic [15:0] pick_distance();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, LASER_FLOOR - 1);
      1: v = $urandom_range(0, 65535);
      2: v = int'(cfg_model.stop_distance) + int'($urandom_range(0, 6)) - 3;
      3: v = int'(cfg_model.near_distance) + int'($urandom_range(0, 6)) - 3;
      4: v = int'(cfg_model.far_distance) + int'($urandom_range(0, 6)) - 3;
      default: v = $urandom_range(LASER_FLOOR, 4000);
    endcase
    return 16'(clamp_int(v, 0, 65535));
  endfunction

  // Joystick axis: full range, near the clamp, or near the deadband.
  function automatic logic signed [15:0] pick_command(input int span, input int dead);
    int v;
    case ($urandom_range(0, 2))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = int'($urandom_range(0, 2 * (span + 100))) - (span + 100);
      default: v = int'($urandom_range(0, 2 * (dead + 5))) - (dead + 5);
    endcase
    return 16'(v);
  endfunction

  // Mostly well-formed scans with random content, plus sonar, joystick and cycles.
  task automatic random_request(output drive_req_t r);
    int unsigned pick;
    int side;
    bit first;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      side = $urandom_range(0, 1);
      first = (laser_cursor[side] == 0) || ($urandom_range(0, 99) < 3);
      laser_cursor[side] = first ? 1 : laser_cursor[side] + 1;
      // Now and then the next scan start is left unmarked to force an overrun.
      if (laser_cursor[side] >= scan_len())
        laser_cursor[side] = ($urandom_range(0, 9) == 0) ? 1 : 0;
      r = laser_req(side[0], first, pick_distance());
    end else if (pick < 70) begin
      r = sonar_req(4'($urandom_range(0, 15)), pick_distance());
    end else if (pick < 82) begin
      r = joy_req(pick_command(ADV_LIMIT, ADV_DEAD), pick_command(TURN_LIMIT, TURN_DEAD));
    end else begin
      r = cycle_req($urandom_range(0, 19) != 0);
    end
  endtask

  // Offer one request after an optional random gap and wait for acceptance.
  task automatic send_request(input drive_req_t r);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.func         <= r.func;
    in_chan.laser_side   <= r.laser_side;
    in_chan.first_sample <= r.first_sample;
    in_chan.distance     <= r.distance;
    in_chan.sonar_index  <= r.sonar_index;
    in_chan.advance_cmd  <= r.advance_cmd;
    in_chan.turn_cmd     <= r.turn_cmd;
    in_chan.link_ok      <= r.link_ok;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    predict_governor(r);
  endtask

  // Stop offering requests and let every pending result drain out.
  task automatic wait_for_quiet();
    in_chan.valid <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers; unused upper data bits carry random values.
  task automatic apply_settings(input logic en, input logic [15:0] stop_mm,
                                input logic [15:0] near_mm, input logic [15:0] far_mm,
                                input logic [10:0] points);
    logic [15:0] vals[5];
    vals[0] = {15'($urandom), en};
    vals[1] = stop_mm;
    vals[2] = near_mm;
    vals[3] = far_mm;
    vals[4] = {5'($urandom), points};
    for (int i = 0; i < 5; i++) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= osg_reg_t'(i);
      cfg_chan.data  <= vals[i];
      @(posedge clk);
      while (cfg_chan.ready !== 1'b1) @(posedge clk);
      case (osg_reg_t'(i))
        REG_LIMITER_ENABLE: cfg_model.limiter_enable = vals[i][0];
        REG_STOP_DISTANCE:  cfg_model.stop_distance  = vals[i];
        REG_NEAR_DISTANCE:  cfg_model.near_distance  = vals[i];
        REG_FAR_DISTANCE:   cfg_model.far_distance   = vals[i];
        default:            cfg_model.scan_points    = vals[i][10:0];
      endcase
    end
    cfg_chan.valid <= 1'b0;
    settings_applied++;
  endtask

  // Clamps, deadband edges and a lost link with the limiter off.
  task automatic test_command_path();
    send_request(joy_req(16'sh7FFF, 16'sh7FFF));
    send_request(cycle_req(1'b1));
    send_request(joy_req(-16'sh8000, -16'sh8000));
    send_request(cycle_req(1'b1));
    send_request(joy_req(16'sd39, -16'sd1));
    send_request(cycle_req(1'b1));
    send_request(joy_req(-16'sd40, 16'sd2));
    send_request(cycle_req(1'b1));
    send_request(cycle_req(1'b0));
    wait_for_quiet();
  endtask

  // With the limiter on and no data yet, stored distances of zero force a stop.
  task automatic test_no_data();
    apply_settings(1'b1, RST_STOP_DISTANCE, RST_NEAR_DISTANCE, RST_FAR_DISTANCE, 11'd3);
    send_request(joy_req(16'sd500, 16'sd50));
    send_request(cycle_req(1'b1));
    send_request(joy_req(-16'sd500, -16'sd50));
    send_request(cycle_req(1'b1));
    wait_for_quiet();
  endtask

  // Three-point scans: floor and fill repair, overrun and an early restart.
  task automatic test_scan_cases();
    send_request(laser_req(1'b0, 1'b1, 16'd0));
    send_request(laser_req(1'b0, 1'b0, 16'd150));
    send_request(laser_req(1'b0, 1'b0, 16'hFFFF));
    send_request(sonar_req(4'd0, 16'hFFFF));
    send_request(sonar_req(4'd15, 16'd0));
    send_request(joy_req(16'sd500, -16'sd100));
    send_request(cycle_req(1'b1));
    // The next sample carries no start mark but the scan is already full.
    send_request(laser_req(1'b0, 1'b0, 16'd1000));
    send_request(laser_req(1'b0, 1'b0, 16'd1800));
    send_request(laser_req(1'b0, 1'b0, 16'd5));
    send_request(laser_req(1'b1, 1'b1, 16'd300));
    send_request(laser_req(1'b1, 1'b1, 16'd400));
    send_request(cycle_req(1'b1));
    wait_for_quiet();
  endtask

  // Random traffic over a series of register settings, extremes included.
  task automatic test_random_mix();
    drive_req_t r;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    for (int phase = 0; phase < 8; phase++) begin
      a = $urandom_range(0, 3000);
      b = a + $urandom_range(0, 2000);
      c = b + $urandom_range(0, 3000);
      case (phase)
        0: apply_settings(1'b1, 16'd600, 16'd1200, 16'd2000, 11'd6);
        1: apply_settings(1'b1, 16'd0, 16'd0, 16'd0, 11'd0);
        2: apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'h7FF);
        3: apply_settings(1'b0, a, b, c, 11'($urandom_range(3, 40)));
        4: apply_settings(1'b1, a, b, c, 11'($urandom_range(3, 40)));
        5: apply_settings(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 11'd1);
        default: apply_settings(1'b1, a, b, c, 11'($urandom_range(3, 12)));
      endcase
      // One phase runs with neither side idling.
      calm = (phase == 6);
      repeat (RANDOM_PER_PHASE) begin
        random_request(r);
        send_request(r);
      end
      calm = 1'b0;
      wait_for_quiet();
    end
  endtask

  // One full scan at the largest length, with commands checked along the way.
  task automatic test_long_scan();
    logic [15:0] d;
    apply_settings(1'b1, 16'd600, 16'd1200, 16'd2000, 11'd1024);
    for (int i = 0; i < SCAN_CAP; i++) begin
      d = ($urandom_range(0, 9) == 0) ? pick_distance() : 16'($urandom_range(200, 4000));
      send_request(laser_req(1'b0, i == 0, d));
      if (i % 256 == 255) begin
        send_request(joy_req(pick_command(ADV_LIMIT, ADV_DEAD),
                             pick_command(TURN_LIMIT, TURN_DEAD)));
        send_request(cycle_req(1'b1));
      end
    end
    send_request(joy_req(16'sd700, 16'sd20));
    send_request(cycle_req(1'b1));
    wait_for_quiet();
  endtask

  // The result side holds off while control cycles keep coming, filling the block.
  task automatic test_output_stall();
    calm = 1'b1;
    stall_request++;
    send_request(joy_req(16'sd900, 16'sd60));
    repeat (40) send_request(cycle_req(1'b1));
    calm = 1'b0;
    wait_for_quiet();
  endtask

  // Result-side ready: random idling, or a counted hold-off when one is asked for.
  always @(posedge clk) begin
    if (stall_taken != stall_request) begin
      stall_taken    <= stall_request;
      stall_left     <= STALL_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left     <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each accepted result with the oldest pending expectation.
  always @(posedge clk) begin : check_speeds
    speed_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (expected_speeds.size() == 0) begin
        $error("unexpected speed result: advance_speed %0d, turn_rate %0d",
               out_chan.advance_speed, out_chan.turn_rate);
        mismatches++;
      end else begin
        want = expected_speeds.pop_front();
        speeds_checked++;
        if (out_chan.advance_speed !== want.advance_speed) begin
          $error("advance_speed: expected %0d, got %0d",
                 want.advance_speed, out_chan.advance_speed);
          mismatches++;
        end
        if (out_chan.turn_rate !== want.turn_rate) begin
          $error("turn_rate: expected %0d, got %0d", want.turn_rate, out_chan.turn_rate);
          mismatches++;
        end
        if (out_chan.limit_source !== want.limit_source) begin
          $error("limit_source: expected %0d, got %0d",
                 want.limit_source, out_chan.limit_source);
          mismatches++;
        end
      end
    end
  end

  // Reset, then run the tests in order.
  initial begin
    in_chan.valid        <= 1'b0;
    in_chan.func         <= KIND_LASER;
    in_chan.laser_side   <= 1'b0;
    in_chan.first_sample <= 1'b0;
    in_chan.distance     <= '0;
    in_chan.sonar_index  <= '0;
    in_chan.advance_cmd  <= '0;
    in_chan.turn_cmd     <= '0;
    in_chan.link_ok      <= 1'b0;
    cfg_chan.valid       <= 1'b0;
    cfg_chan.index       <= REG_LIMITER_ENABLE;
    cfg_chan.data        <= '0;
    rst_n                <= 1'b0;
    for (int k = 0; k < 4; k++) kind_seen[k] = 0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_command_path();
    test_no_data();
    test_scan_cases();
    test_random_mix();
    test_long_scan();
    test_output_stall();

    $display("Covered %0d laser, %0d sonar, %0d joystick and %0d control requests.",
             kind_seen[KIND_LASER], kind_seen[KIND_SONAR], kind_seen[KIND_JOY],
             kind_seen[KIND_CYCLE]);
    $display("Checked %0d speed results over %0d register settings and a %0d-cycle stall.",
             speeds_checked, settings_applied, STALL_CYCLES);
    if (mismatches == 0) begin
      $display("obstacle_speed_governor_unit_test: PASS");
    end else begin
      $display("obstacle_speed_governor_unit_test: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/osg_pkg.sv
rtl/osg_if.sv
rtl/osg_cfg_regs.sv
rtl/osg_front.sv
rtl/osg_queue.sv
rtl/osg_back.sv
rtl/obstacle_speed_governor_unit.sv
rtl/osg_chk.sv
tb/obstacle_speed_governor_unit_test.sv
